/* hdl/ivti_pkg.sv */
`default_nettype none
package ivti_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SEARCH_LEVELS = IDX_W + 1;
    localparam int DIV_WIDTH = 64;
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES = DIV_WIDTH / DIV_BITS_PER_STAGE;
    localparam int Q_CLAMP_BIT = 40;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } ivti_op_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_LOW   = 3'd1,
        ST_HIGH  = 3'd2,
        ST_EMPTY = 3'd3,
        ST_FULL  = 3'd4
    } ivti_status_t;

    // Search window: lo, hi and probe position
    typedef struct packed {
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [IDX_W-1:0] pos;
    } ivti_srch_t;

    // Item sideband through search and pair fetch
    typedef struct packed {
        logic         search;
        ivti_status_t status;
        logic [31:0]  amps;
        logic [31:0]  x;
    } ivti_tag_t;

    // Item sideband through multiply and divide
    typedef struct packed {
        logic         interp;
        logic         neg;
        ivti_status_t status;
        logic [31:0]  amps;
    } ivti_tail_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [31:0]      volts;
        logic [31:0]      amps;
    } ivti_wr_t;

endpackage
`default_nettype wire

/* hdl/ivti_search.sv */
`default_nettype none
module ivti_search (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire ivti_pkg::ivti_wr_t  wr,
    input  wire logic                in_valid,
    input  wire ivti_pkg::ivti_srch_t in_state,
    input  wire ivti_pkg::ivti_tag_t in_tag,
    output logic                     out_valid,
    output ivti_pkg::ivti_srch_t     out_state,
    output ivti_pkg::ivti_tag_t      out_tag,
    output logic                     busy
);

    localparam int NL = ivti_pkg::SEARCH_LEVELS;
    localparam int IW = ivti_pkg::IDX_W;

    logic [31:0]          vmem [NL][ivti_pkg::TABLE_DEPTH];
    logic [31:0]          vdat_reg [NL];
    ivti_pkg::ivti_srch_t state_reg [NL];
    ivti_pkg::ivti_tag_t  tag_reg [NL];
    logic [NL-1:0]        valid_reg;

    ivti_pkg::ivti_srch_t state_in [NL];
    ivti_pkg::ivti_tag_t  tag_in [NL];
    logic [NL-1:0]        valid_in;
    ivti_pkg::ivti_srch_t stepped [NL];

    function automatic ivti_pkg::ivti_srch_t srch_step(ivti_pkg::ivti_srch_t s,
                                                      logic [31:0] v, logic [31:0] x);
        ivti_pkg::ivti_srch_t r;
        logic [IW-1:0]        gap;
        r = s;
        gap = '0;
        if ((s.hi - s.lo) > IW'(1)) begin
            if ($signed(v) > $signed(x)) begin
                gap = s.pos - s.lo;
                r.hi = s.pos;
                r.pos = s.lo + (gap >> 1);
            end else begin
                gap = s.hi - s.pos;
                r.lo = s.pos;
                r.pos = s.hi - (gap >> 1);
            end
        end
        return r;
    endfunction

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            stepped[k] = srch_step(state_reg[k], vdat_reg[k], tag_reg[k].x);
        end
        state_in[0] = in_state;
        tag_in[0] = in_tag;
        valid_in[0] = in_valid;
        for (int k = 1; k < NL; k++) begin
            state_in[k] = stepped[k-1];
            tag_in[k] = tag_reg[k-1];
            valid_in[k] = valid_reg[k-1];
        end
    end

    // Every level keeps its own copy of the voltages so each can probe in the same cycle
    always_ff @(posedge aclk) begin
        for (int k = 0; k < NL; k++) begin
            if (wr.en) begin
                vmem[k][wr.addr] <= wr.volts;
            end
            if (en) begin
                vdat_reg[k] <= vmem[k][state_in[k].pos];
                state_reg[k] <= state_in[k];
                tag_reg[k] <= tag_in[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_comb begin
        busy = 1'b0;
        for (int k = 0; k < NL; k++) begin
            busy = busy | (valid_reg[k] & tag_reg[k].search);
        end
    end

    assign out_valid = valid_reg[NL-1];
    assign out_state = stepped[NL-1];
    assign out_tag = tag_reg[NL-1];

endmodule
`default_nettype wire

/* hdl/ivti_pair_fetch.sv */
`default_nettype none
module ivti_pair_fetch (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire ivti_pkg::ivti_wr_t   wr,
    input  wire logic                 in_valid,
    input  wire ivti_pkg::ivti_srch_t in_state,
    input  wire ivti_pkg::ivti_tag_t  in_tag,
    output logic                      out_valid,
    output ivti_pkg::ivti_tag_t       out_tag,
    output logic [31:0]               vlo,
    output logic [31:0]               vhi,
    output logic [31:0]               ilo,
    output logic [31:0]               ihi
);

    logic [31:0] vmem [ivti_pkg::TABLE_DEPTH];
    logic [31:0] imem [ivti_pkg::TABLE_DEPTH];
    logic [31:0] vlo_reg, vhi_reg, ilo_reg, ihi_reg;
    ivti_pkg::ivti_tag_t tag_reg;
    logic valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            vmem[wr.addr] <= wr.volts;
            imem[wr.addr] <= wr.amps;
        end
        if (en) begin
            vlo_reg <= vmem[in_state.lo];
            vhi_reg <= vmem[in_state.hi];
            ilo_reg <= imem[in_state.lo];
            ihi_reg <= imem[in_state.hi];
            tag_reg <= in_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid = valid_reg;
    assign out_tag = tag_reg;
    assign vlo = vlo_reg;
    assign vhi = vhi_reg;
    assign ilo = ilo_reg;
    assign ihi = ihi_reg;

endmodule
`default_nettype wire

/* hdl/ivti_divider.sv */
`default_nettype none
module ivti_divider (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [63:0]         dividend,
    input  wire logic [31:0]         divisor,
    input  wire ivti_pkg::ivti_tail_t in_tail,
    output logic                     out_valid,
    output logic [63:0]              quotient,
    output ivti_pkg::ivti_tail_t     out_tail
);

    localparam int NS = ivti_pkg::DIV_STAGES;
    localparam int BPS = ivti_pkg::DIV_BITS_PER_STAGE;

    logic [31:0]          rem_reg [NS];
    logic [63:0]          work_reg [NS];
    logic [31:0]          div_reg [NS];
    ivti_pkg::ivti_tail_t tail_reg [NS];
    logic [NS-1:0]        valid_reg;

    logic [31:0] rem_next [NS];
    logic [63:0] work_next [NS];

    // Restoring division: work shifts dividend bits out the top and quotient bits in
    always_comb begin
        logic [31:0] r;
        logic [63:0] w;
        logic [32:0] t;
        logic        ge;
        for (int s = 0; s < NS; s++) begin
            r = (s == 0) ? 32'd0 : rem_reg[(s == 0) ? 0 : s - 1];
            w = (s == 0) ? dividend : work_reg[(s == 0) ? 0 : s - 1];
            for (int b = 0; b < BPS; b++) begin
                t = {r, w[63]};
                ge = (t >= {1'b0, ((s == 0) ? divisor : div_reg[(s == 0) ? 0 : s - 1])});
                if (ge) begin
                    t = t - {1'b0, ((s == 0) ? divisor : div_reg[(s == 0) ? 0 : s - 1])};
                end
                r = t[31:0];
                w = {w[62:0], ge};
            end
            rem_next[s] = r;
            work_next[s] = w;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < NS; s++) begin
                rem_reg[s] <= rem_next[s];
                work_reg[s] <= work_next[s];
            end
            div_reg[0] <= divisor;
            tail_reg[0] <= in_tail;
            for (int s = 1; s < NS; s++) begin
                div_reg[s] <= div_reg[s-1];
                tail_reg[s] <= tail_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NS-2:0], in_valid};
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign quotient = work_reg[NS-1];
    assign out_tail = tail_reg[NS-1];

endmodule
`default_nettype wire

/* hdl/iv_table_interpolator_core.sv */
`default_nettype none
// Piecewise-linear current-versus-voltage table. Append points in ascending voltage
// order, clear the table, or query a voltage; every item yields exactly one result.
// Queries enter at one per cycle unless the result side stalls, and pass through
// one search level per index bit plus one, a pair fetch, a 32x32 multiply and a
// 64-by-32 divider retiring four quotient bits per stage. An append, clear or no-op
// is held off while a query that needs a search is still in the search or pair-fetch
// stages, because those stages read the point memories. A stall on the result side
// freezes the whole pipeline.
module iv_table_interpolator_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [31:0] s_volts,
    input  wire logic [31:0] s_amps,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_result_amps,
    output logic [2:0]       m_status
);

    localparam int IW = ivti_pkg::IDX_W;
    localparam int CW = ivti_pkg::CNT_W;

    logic en, s_fire, full, busy, srch_busy;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0] first_v_reg, first_i_reg, last_v_reg, last_i_reg;

    ivti_pkg::ivti_srch_t st0;
    ivti_pkg::ivti_tag_t  tag0;
    ivti_pkg::ivti_wr_t   wr;

    logic                 sr_valid;
    ivti_pkg::ivti_srch_t sr_state;
    ivti_pkg::ivti_tag_t  sr_tag;

    logic                f_valid;
    ivti_pkg::ivti_tag_t f_tag;
    logic [31:0]         f_vlo, f_vhi, f_ilo, f_ihi;

    logic [32:0] da, db, dd;
    ivti_pkg::ivti_tail_t m1_tail_next;
    logic m1_valid_reg, m2_valid_reg;
    ivti_pkg::ivti_tail_t m1_tail_reg, m2_tail_reg;
    logic [31:0] m1_ma_reg, m1_mb_reg, m1_md_reg, m2_md_reg;
    logic [63:0] m2_prod_reg;

    logic                 d_valid;
    logic [63:0]          d_q;
    ivti_pkg::ivti_tail_t d_tail;

    logic [40:0] qc;
    logic [42:0] sq, sum;
    logic [31:0] res_next;

    logic        m_valid_reg;
    logic [31:0] m_result_amps_reg;
    logic [2:0]  m_status_reg;

    assign en = !m_valid_reg || m_ready;
    assign full = (count_reg == CW'(ivti_pkg::TABLE_DEPTH));
    assign busy = srch_busy || (f_valid && f_tag.search);
    assign s_ready = en && !(s_operation != ivti_pkg::OP_QUERY && busy);
    assign s_fire = s_valid && s_ready;

    always_comb begin
        tag0.search = 1'b0;
        tag0.status = ivti_pkg::ST_OK;
        tag0.amps = '0;
        tag0.x = s_volts;
        st0.lo = '0;
        st0.hi = IW'(count_reg - CW'(1));
        st0.pos = IW'(count_reg >> 1);
        wr.en = 1'b0;
        wr.addr = IW'(count_reg);
        wr.volts = s_volts;
        wr.amps = s_amps;
        count_next = count_reg;
        case (ivti_pkg::ivti_op_t'(s_operation))
            ivti_pkg::OP_APPEND: begin
                if (full) begin
                    tag0.status = ivti_pkg::ST_FULL;
                end else begin
                    wr.en = s_fire;
                    if (s_fire) begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            ivti_pkg::OP_QUERY: begin
                if (count_reg == '0) begin
                    tag0.status = ivti_pkg::ST_EMPTY;
                end else if ($signed(s_volts) < $signed(first_v_reg)) begin
                    tag0.status = ivti_pkg::ST_LOW;
                    tag0.amps = first_i_reg;
                end else if ($signed(s_volts) > $signed(last_v_reg)) begin
                    tag0.status = ivti_pkg::ST_HIGH;
                    tag0.amps = last_i_reg;
                end else begin
                    tag0.search = 1'b1;
                end
            end
            ivti_pkg::OP_CLEAR: begin
                if (s_fire) begin
                    count_next = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // End points kept in registers for the clip checks at entry
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            last_v_reg <= s_volts;
            last_i_reg <= s_amps;
            if (count_reg == '0) begin
                first_v_reg <= s_volts;
                first_i_reg <= s_amps;
            end
        end
    end

    ivti_search u_search (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .wr        (wr),
        .in_valid  (s_fire),
        .in_state  (st0),
        .in_tag    (tag0),
        .out_valid (sr_valid),
        .out_state (sr_state),
        .out_tag   (sr_tag),
        .busy      (srch_busy)
    );

    ivti_pair_fetch u_fetch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .wr        (wr),
        .in_valid  (sr_valid),
        .in_state  (sr_state),
        .in_tag    (sr_tag),
        .out_valid (f_valid),
        .out_tag   (f_tag),
        .vlo       (f_vlo),
        .vhi       (f_vhi),
        .ilo       (f_ilo),
        .ihi       (f_ihi)
    );

    always_comb begin
        da = {f_ihi[31], f_ihi} - {f_ilo[31], f_ilo};
        db = {f_tag.x[31], f_tag.x} - {f_vlo[31], f_vlo};
        dd = {f_vhi[31], f_vhi} - {f_vlo[31], f_vlo};
        m1_tail_next.neg = da[32] ^ db[32] ^ dd[32];
        if (!f_tag.search) begin
            m1_tail_next.interp = 1'b0;
            m1_tail_next.status = f_tag.status;
            m1_tail_next.amps = f_tag.amps;
        end else begin
            // zero span falls back to the lower point's current
            m1_tail_next.interp = (dd != '0);
            m1_tail_next.status = ivti_pkg::ST_OK;
            m1_tail_next.amps = f_ilo;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_tail_reg <= m1_tail_next;
            m1_ma_reg <= da[32] ? 32'(-da) : da[31:0];
            m1_mb_reg <= db[32] ? 32'(-db) : db[31:0];
            m1_md_reg <= dd[32] ? 32'(-dd) : dd[31:0];
            m2_tail_reg <= m1_tail_reg;
            m2_prod_reg <= 64'(m1_ma_reg) * 64'(m1_mb_reg);
            m2_md_reg <= m1_md_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
        end else if (en) begin
            m1_valid_reg <= f_valid;
            m2_valid_reg <= m1_valid_reg;
        end
    end

    ivti_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (m2_valid_reg),
        .dividend  (m2_prod_reg),
        .divisor   (m2_md_reg),
        .in_tail   (m2_tail_reg),
        .out_valid (d_valid),
        .quotient  (d_q),
        .out_tail  (d_tail)
    );

    // Clamp quotient, sign it, add base current, saturate; non-interp: base current
    always_comb begin
        if (d_q > (64'd1 << ivti_pkg::Q_CLAMP_BIT)) begin
            qc = 41'd1 << ivti_pkg::Q_CLAMP_BIT;
        end else begin
            qc = d_q[40:0];
        end
        sq = d_tail.neg ? -{2'b00, qc} : {2'b00, qc};
        sum = {{11{d_tail.amps[31]}}, d_tail.amps} + sq;
        if (!d_tail.interp) begin
            res_next = d_tail.amps;
        end else if (!sum[42] && (sum[41:31] != '0)) begin
            res_next = 32'h7fff_ffff;
        end else if (sum[42] && (sum[41:31] != '1)) begin
            res_next = 32'h8000_0000;
        end else begin
            res_next = sum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_result_amps_reg <= res_next;
            m_status_reg <= d_tail.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d_valid;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_result_amps = m_result_amps_reg;
    assign m_status = m_status_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(ivti_pkg::TABLE_DEPTH))
        else $error("point count beyond table depth");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation == ivti_pkg::OP_CLEAR |=> count_reg == '0)
        else $error("clear did not empty the table");

    a_no_write_under_search: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> !busy)
        else $error("table written while a query reads it");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ivti_pkg::ST_EMPTY || m_status == ivti_pkg::ST_FULL)
        |-> m_result_amps == '0)
        else $error("nonzero current with empty or full status");

endmodule
`default_nettype wire
